// ----- rtl/lprsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lprsd_pkg
// Shared types and constants of the raster stream decoder: event codes,
// command bytes and the result word carried from the decoder to the output
// register.
// ----------------------------------------------------------------------------
package lprsd_pkg;

  localparam int HEAD_DOTS_DEF = 1024;

  // command and argument bytes
  localparam logic [7:0] CMD_NUL     = 8'h00;
  localparam logic [7:0] CMD_FF      = 8'h0c;
  localparam logic [7:0] CMD_CTRLZ   = 8'h1a;
  localparam logic [7:0] CMD_ESC     = 8'h1b;
  localparam logic [7:0] CH_LOWER_I  = 8'h69;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_S        = 8'h53;
  localparam logic [7:0] CH_M        = 8'h4d;
  localparam logic [7:0] CH_LOWER_D  = 8'h64;
  localparam logic [7:0] CH_K        = 8'h4b;
  localparam logic [7:0] CH_R        = 8'h52;
  localparam logic [7:0] CH_G        = 8'h47;
  localparam logic [7:0] CH_Z        = 8'h5a;
  localparam logic [7:0] XFER_RASTER = 8'h01;
  localparam logic [7:0] COMP_PACKBITS = 8'h02;
  localparam logic [7:0] PB_RUN_BIT  = 8'h80;
  localparam logic [8:0] PB_RUN_BASE = 9'd257;

  localparam logic [15:0] BAUD_96   = 16'd96;
  localparam logic [15:0] BAUD_576  = 16'd576;
  localparam logic [15:0] BAUD_1152 = 16'd1152;

  localparam int HEIGHT_INIT = 128;

  typedef enum logic [3:0] {
    EV_RUN        = 4'd0,
    EV_ROW_END    = 4'd1,
    EV_BLANK_COL  = 4'd2,
    EV_COMP_SET   = 4'd3,
    EV_FORMFEED   = 4'd4,
    EV_CTRLZ      = 4'd5,
    EV_UNKNOWN    = 4'd6,
    EV_BAUD       = 4'd7,
    EV_MODE       = 4'd8,
    EV_MARGIN     = 4'd9,
    EV_EXPANDED   = 4'd10,
    EV_STATUS     = 4'd11,
    EV_INIT       = 4'd12,
    EV_NULL       = 4'd13,
    EV_BAD_XFER   = 4'd14
  } event_e;

  typedef struct packed {
    logic        valid;
    event_e      ev;
    logic [7:0]  data_byte;
    logic [7:0]  repeat_count;
    logic [15:0] value;
    logic [15:0] column;
    logic        row_end;
    logic        flagged;
  } res_t;

endpackage

// ----- rtl/lprsd_decode.sv -----
// ----------------------------------------------------------------------------
// lprsd_decode
// Parser state, row counters and the combinational decode of one stream byte
// into at most one result word.
// ----------------------------------------------------------------------------
module lprsd_decode #(
  parameter int HEAD_DOTS = lprsd_pkg::HEAD_DOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output lprsd_pkg::res_t   res_o
);
  import lprsd_pkg::*;

  localparam int RowCap = HEAD_DOTS / 8;
  localparam int RFW    = $clog2(RowCap + 1);
  localparam int HW     = ($clog2(HEAD_DOTS + 1) > 8) ? $clog2(HEAD_DOTS + 1) : 8;
  localparam int CW     = (RFW > 8) ? RFW : 8;
  localparam int MW     = (HW > RFW + 3) ? HW : RFW + 3;

  typedef enum logic [17:0] {
    PH_TOP       = 18'h00001,
    PH_ESC       = 18'h00002,
    PH_ESC_I     = 18'h00004,
    PH_BAUD_LO   = 18'h00008,
    PH_BAUD_HI   = 18'h00010,
    PH_MODE      = 18'h00020,
    PH_MARGIN_LO = 18'h00040,
    PH_MARGIN_HI = 18'h00080,
    PH_EXPANDED  = 18'h00100,
    PH_XFER      = 18'h00200,
    PH_R_IDLE    = 18'h00400,
    PH_R_COMP    = 18'h00800,
    PH_R_LEN_LO  = 18'h01000,
    PH_R_LEN_HI  = 18'h02000,
    PH_R_PREFIX  = 18'h04000,
    PH_R_RUNVAL  = 18'h08000,
    PH_R_COPY    = 18'h10000,
    PH_R_RAW     = 18'h20000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            raw_mode_q, raw_mode_d;
  logic [15:0]     payload_left_q, payload_left_d;
  logic [7:0]      op_left_q, op_left_d;
  logic [7:0]      arg_low_q, arg_low_d;
  logic [RFW-1:0]  row_fill_q, row_fill_d;
  logic [HW-1:0]   image_height_q, image_height_d;
  logic [15:0]     column_q, column_d;

  logic [CW-1:0]   room, count_w, stored_w;
  logic [7:0]      run_count;
  logic            run_flag;
  logic [RFW-1:0]  fill_new, fill_sel;
  logic [MW-1:0]   fill_dots, height_ext;
  logic [HW-1:0]   height_closed;
  logic [15:0]     payload_dec, column_inc, arg_word;
  logic            payload_last;
  logic            run_op, row_end_op;
  res_t            res;

  // run storage against the row buffer
  assign run_count = (phase_q == PH_R_RUNVAL) ? op_left_q : 8'd1;
  assign room      = CW'(RowCap) - CW'(row_fill_q);
  assign count_w   = CW'(run_count);
  assign stored_w  = (count_w < room) ? count_w : room;
  assign run_flag  = (count_w > room);
  assign fill_new  = row_fill_q + RFW'(stored_w);

  always_comb begin
    case (phase_q)
      PH_R_RUNVAL, PH_R_COPY, PH_R_RAW: fill_sel = fill_new;
      PH_R_LEN_HI:                      fill_sel = '0;
      default:                          fill_sel = row_fill_q;
    endcase
  end

  // height after closing a row: max of height and 8 dots per byte
  assign fill_dots     = MW'(fill_sel) << 3;
  assign height_ext    = MW'(image_height_q);
  assign height_closed = HW'((fill_dots > height_ext) ? fill_dots : height_ext);

  assign payload_dec  = payload_left_q - 16'd1;
  assign payload_last = (payload_dec == 16'd0);
  assign column_inc   = (column_q != 16'hffff) ? column_q + 16'd1 : column_q;
  assign arg_word     = {byte_i, arg_low_q};

  always_comb begin
    phase_d        = phase_q;
    raw_mode_d     = raw_mode_q;
    payload_left_d = payload_left_q;
    op_left_d      = op_left_q;
    arg_low_d      = arg_low_q;
    row_fill_d     = row_fill_q;
    image_height_d = image_height_q;
    column_d       = column_q;
    run_op         = 1'b0;
    row_end_op     = 1'b0;
    res            = '0;
    res.ev         = EV_RUN;
    res.column     = column_q;

    case (phase_q)
      PH_TOP: begin
        res.valid = 1'b1;
        if (byte_i == CMD_NUL) begin
          res.ev = EV_NULL;
        end else if (byte_i == CMD_FF) begin
          res.ev = EV_FORMFEED;
        end else if (byte_i == CMD_CTRLZ) begin
          res.ev = EV_CTRLZ;
        end else if (byte_i == CMD_ESC) begin
          res.valid = 1'b0;
          phase_d   = PH_ESC;
        end else begin
          res.ev        = EV_UNKNOWN;
          res.data_byte = byte_i;
        end
      end
      PH_ESC: begin
        phase_d = PH_TOP;
        if (byte_i == CH_LOWER_I) begin
          phase_d = PH_ESC_I;
        end else if (byte_i == CH_AT) begin
          res.valid = 1'b1;
          res.ev    = EV_INIT;
        end else begin
          res.valid     = 1'b1;
          res.ev        = EV_UNKNOWN;
          res.data_byte = byte_i;
        end
      end
      PH_ESC_I: begin
        phase_d = PH_TOP;
        case (byte_i)
          CH_B:       phase_d = PH_BAUD_LO;
          CH_M:       phase_d = PH_MODE;
          CH_LOWER_D: phase_d = PH_MARGIN_LO;
          CH_K:       phase_d = PH_EXPANDED;
          CH_R:       phase_d = PH_XFER;
          CH_S: begin
            res.valid = 1'b1;
            res.ev    = EV_STATUS;
          end
          default: begin
            res.valid     = 1'b1;
            res.ev        = EV_UNKNOWN;
            res.data_byte = byte_i;
          end
        endcase
      end
      PH_BAUD_LO: begin
        arg_low_d = byte_i;
        phase_d   = PH_BAUD_HI;
      end
      PH_BAUD_HI: begin
        phase_d     = PH_TOP;
        res.valid   = 1'b1;
        res.ev      = EV_BAUD;
        res.value   = arg_word;
        res.flagged = !(arg_word == BAUD_96 || arg_word == BAUD_576 ||
                        arg_word == BAUD_1152);
      end
      PH_MODE: begin
        phase_d       = PH_TOP;
        res.valid     = 1'b1;
        res.ev        = EV_MODE;
        res.data_byte = byte_i;
      end
      PH_MARGIN_LO: begin
        arg_low_d = byte_i;
        phase_d   = PH_MARGIN_HI;
      end
      PH_MARGIN_HI: begin
        phase_d   = PH_TOP;
        res.valid = 1'b1;
        res.ev    = EV_MARGIN;
        res.value = arg_word;
      end
      PH_EXPANDED: begin
        phase_d       = PH_TOP;
        res.valid     = 1'b1;
        res.ev        = EV_EXPANDED;
        res.data_byte = byte_i;
      end
      PH_XFER: begin
        if (byte_i == XFER_RASTER) begin
          phase_d        = PH_R_IDLE;
          raw_mode_d     = 1'b0;
          row_fill_d     = '0;
          image_height_d = HW'(HEIGHT_INIT);
          column_d       = '0;
        end else begin
          phase_d       = PH_TOP;
          res.valid     = 1'b1;
          res.ev        = EV_BAD_XFER;
          res.data_byte = byte_i;
        end
      end
      PH_R_IDLE: begin
        if (byte_i == CH_M) begin
          phase_d = PH_R_COMP;
        end else if (byte_i == CH_G) begin
          phase_d = PH_R_LEN_LO;
        end else if (byte_i == CH_Z) begin
          res.valid = 1'b1;
          res.ev    = EV_BLANK_COL;
          column_d  = column_inc;
        end else if (byte_i == CMD_FF) begin
          phase_d   = PH_TOP;
          res.valid = 1'b1;
          res.ev    = EV_FORMFEED;
        end else if (byte_i == CMD_CTRLZ) begin
          phase_d   = PH_TOP;
          res.valid = 1'b1;
          res.ev    = EV_CTRLZ;
        end else begin
          res.valid     = 1'b1;
          res.ev        = EV_UNKNOWN;
          res.data_byte = byte_i;
        end
      end
      PH_R_COMP: begin
        raw_mode_d    = (byte_i != COMP_PACKBITS);
        phase_d       = PH_R_IDLE;
        res.valid     = 1'b1;
        res.ev        = EV_COMP_SET;
        res.data_byte = byte_i;
      end
      PH_R_LEN_LO: begin
        arg_low_d = byte_i;
        phase_d   = PH_R_LEN_HI;
      end
      PH_R_LEN_HI: begin
        payload_left_d = arg_word;
        row_fill_d     = '0;
        if (arg_word == 16'd0) begin
          row_end_op = 1'b1;
        end else begin
          phase_d = raw_mode_q ? PH_R_RAW : PH_R_PREFIX;
        end
      end
      PH_R_PREFIX: begin
        payload_left_d = payload_dec;
        if ((byte_i & PB_RUN_BIT) != 8'h00) begin
          op_left_d = 8'(PB_RUN_BASE - {1'b0, byte_i});
          phase_d   = PH_R_RUNVAL;
        end else begin
          op_left_d = byte_i + 8'd1;
          phase_d   = PH_R_COPY;
        end
        row_end_op = payload_last;
      end
      PH_R_RUNVAL: begin
        payload_left_d = payload_dec;
        phase_d        = PH_R_PREFIX;
        run_op         = 1'b1;
      end
      PH_R_COPY: begin
        payload_left_d = payload_dec;
        op_left_d      = op_left_q - 8'd1;
        phase_d        = (op_left_q == 8'd1) ? PH_R_PREFIX : PH_R_COPY;
        run_op         = 1'b1;
      end
      PH_R_RAW: begin
        payload_left_d = payload_dec;
        run_op         = 1'b1;
      end
      default: begin
        phase_d = PH_TOP;
      end
    endcase

    // row ends with no bytes left for a final run
    if (row_end_op) begin
      phase_d        = PH_R_IDLE;
      image_height_d = height_closed;
      column_d       = column_inc;
      res.valid      = 1'b1;
      res.ev         = EV_ROW_END;
      res.value      = 16'(height_closed);
      res.row_end    = 1'b1;
    end

    if (run_op) begin
      row_fill_d       = fill_new;
      res.valid        = 1'b1;
      res.ev           = EV_RUN;
      res.data_byte    = byte_i;
      res.repeat_count = 8'(stored_w);
      res.flagged      = run_flag;
      if (payload_last) begin
        phase_d        = PH_R_IDLE;
        image_height_d = height_closed;
        column_d       = column_inc;
        res.value      = 16'(height_closed);
        res.row_end    = 1'b1;
      end else begin
        res.value = 16'(fill_new);
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_TOP;
      raw_mode_q     <= 1'b0;
      payload_left_q <= '0;
      op_left_q      <= '0;
      arg_low_q      <= '0;
      row_fill_q     <= '0;
      image_height_q <= HW'(HEIGHT_INIT);
      column_q       <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      raw_mode_q     <= raw_mode_d;
      payload_left_q <= payload_left_d;
      op_left_q      <= op_left_d;
      arg_low_q      <= arg_low_d;
      row_fill_q     <= row_fill_d;
      image_height_q <= image_height_d;
      column_q       <= column_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_fill_q <= RFW'(RowCap))
    else $error("row fill beyond row buffer");

  a_height_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    image_height_q >= HW'(HEIGHT_INIT))
    else $error("image height below initial height");

  a_row_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.row_end |->
      (res_o.ev == EV_RUN || res_o.ev == EV_ROW_END))
    else $error("row end on a non-row word");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.ev == EV_RUN && res_o.flagged |=>
      row_fill_q == RFW'(RowCap))
    else $error("truncated run left room in the row buffer");

  a_raster_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_XFER && byte_i == XFER_RASTER |=>
      column_q == 16'd0 && image_height_q == HW'(HEIGHT_INIT) && phase_q == PH_R_IDLE)
    else $error("raster entry did not reset column and height");
`endif

endmodule

// ----- rtl/lprsd_out_reg.sv -----
// ----------------------------------------------------------------------------
// lprsd_out_reg
// Result register: holds one decoded word until the consumer takes it and
// reports when it can load the next one.
// ----------------------------------------------------------------------------
module lprsd_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  lprsd_pkg::res_t res_i,
  input  logic            out_ready_i,
  output logic            free_o,
  output logic            valid_o,
  output lprsd_pkg::res_t res_o
);
  import lprsd_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = (load_i && res_i.valid) ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = data_q;

endmodule

// ----- rtl/label_printer_raster_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// label_printer_raster_stream_decoder
// Byte-serial decoder of a raster label-printer command stream: top-level
// commands, raster mode rows (raw or PackBits) reported as runs, blank
// columns and row ends.
//
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_ready_o   stream_byte_i
// out      source     out_valid_o / out_ready_i event_res_o, data_byte_o,
//                                               repeat_count_o, value_o,
//                                               column_o, row_end_o, flagged_o
//
// one byte per cycle unless the output stalls; a byte sits in the input register,
// is decoded combinationally and loaded into the result register, so a result
// shows after passing the input register and then the result register
// bytes that produce no word (escape prefixes, length bytes) pass silently
// a stalled output holds the input register; no other stall source
// rst_ni clears parser phase to top level and sets image height to 128
// ----------------------------------------------------------------------------
module label_printer_raster_stream_decoder #(
  parameter int HEAD_DOTS = lprsd_pkg::HEAD_DOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  repeat_count_o,
  output logic [15:0] value_o,
  output logic [15:0] column_o,
  output logic        row_end_o,
  output logic        flagged_o
);
  import lprsd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       advance, out_free;
  res_t       dec_res, out_res;

  // decode the held byte once the result register can take its word
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = (in_valid_i && in_ready_o) ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
  end

  lprsd_decode #(
    .HEAD_DOTS (HEAD_DOTS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (dec_res)
  );

  lprsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (dec_res),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .valid_o     (out_valid_o),
    .res_o       (out_res)
  );

  assign event_res_o    = out_res.ev;
  assign data_byte_o    = out_res.data_byte;
  assign repeat_count_o = out_res.repeat_count;
  assign value_o        = out_res.value;
  assign column_o       = out_res.column;
  assign row_end_o      = out_res.row_end;
  assign flagged_o      = out_res.flagged;

endmodule
